FILE: design/hcoe_pkg.sv
// ----------------------------------------------------------------------------
// hcoe_pkg: shared types and constants for the handle cache
// Entry layout, command codes, result layout and pool sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package hcoe_pkg;

    localparam int POOL_ENTRIES = 8;
    localparam int MAX_RESULTS  = 8;
    localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int AGE_W    = 32;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef enum logic [1:0] {
        CMD_RELEASE  = 2'd0,
        CMD_FREE_KEY = 2'd1,
        CMD_FREE_ALL = 2'd2,
        CMD_SHUTDOWN = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
    } entry_t;

    typedef struct packed {
        logic                freed_valid;
        logic [HANDLE_W-1:0] freed_handle;
        logic                status;
        logic                last;
    } result_t;

    typedef struct packed {
        logic age_lt;
        logic key_eq;
    } cmp_t;

endpackage

`default_nettype wire

FILE: design/hcoe_entry_store.sv
// ----------------------------------------------------------------------------
// hcoe_entry_store: pool entry storage
// Key, handle and age per entry with one write port and a registered read;
// valid bits in flops cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hcoe_entry_store (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [hcoe_pkg::IDX_W-1:0]     rd_idx,
    output hcoe_pkg::entry_t                    rd_q,
    input  wire logic                           wr_en,
    input  wire logic [hcoe_pkg::IDX_W-1:0]     wr_idx,
    input  wire hcoe_pkg::entry_t               wr_data,
    input  wire logic                           clr_en,
    input  wire logic [hcoe_pkg::IDX_W-1:0]     clr_idx,
    output logic [hcoe_pkg::POOL_ENTRIES-1:0]   valid_vec
);
    import hcoe_pkg::*;

    entry_t mem [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_q <= mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    assign valid_vec = valid_reg;

endmodule

`default_nettype wire

FILE: design/hcoe_cmp_unit.sv
// ----------------------------------------------------------------------------
// hcoe_cmp_unit: shared compare unit
// Age less-than for the eviction search and key match for free-by-key.
// ----------------------------------------------------------------------------
`default_nettype none

module hcoe_cmp_unit (
    input  wire logic [hcoe_pkg::AGE_W-1:0] age_a,
    input  wire logic [hcoe_pkg::AGE_W-1:0] age_b,
    input  wire logic [hcoe_pkg::KEY_W-1:0] key_a,
    input  wire logic [hcoe_pkg::KEY_W-1:0] key_b,
    output hcoe_pkg::cmp_t                  cmp
);
    import hcoe_pkg::*;

    always_comb begin
        cmp.age_lt = (age_a < age_b);
        cmp.key_eq = (key_a == key_b);
    end

endmodule

`default_nettype wire

FILE: design/hcoe_out_reg.sv
// ----------------------------------------------------------------------------
// hcoe_out_reg: result output register
// Holds one result for the master side; takes a new one as the old leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module hcoe_out_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push_valid,
    input  wire hcoe_pkg::result_t             push_data,
    output logic                               push_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hcoe_pkg::HANDLE_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import hcoe_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign push_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push_ready) begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ready && push_valid) begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.freed_handle;
    assign m_tuser  = {data_reg.status, data_reg.freed_valid};
    assign m_tlast  = data_reg.last;

endmodule

`default_nettype wire

FILE: design/handle_cache_oldest_evict_core.sv
// ----------------------------------------------------------------------------
// handle_cache_oldest_evict_core: handle pool with oldest-entry eviction
//
// Slave side takes one command per transfer: s_tuser is the command,
// s_tdata holds owner key and handle. Master side returns one or more
// results per command; m_tlast marks the final one.
// A command is scanned one entry per cycle through a single compare unit
// and a registered entry read, except while a result waits on the receiver:
//   release: stops at the first empty entry, else evicts the oldest at the last
//   free by key / free all / shutdown: every entry, then a final result
//   any command after shutdown: no scan, only the ignored result
// s_tready is high only while no command is in progress; the output
// register lets the next command be taken while the last result still
// waits.
// When m_tready is low the scan holds at the entry that has a result to
// hand over. Synchronous reset empties the pool and clears the age counter
// and shutdown flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_cache_oldest_evict_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] owner_key, [47:32] handle_id
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] freed_handle
    output logic [1:0]       m_tuser,   // [0] freed_valid, [1] status
    output logic             m_tlast
);
    import hcoe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [AGE_W-1:0]     age_cnt_reg, age_cnt_next;
    logic                 shut_reg, shut_next;
    logic [IDX_W-1:0]     oldest_idx_reg, oldest_idx_next;
    logic [AGE_W-1:0]     oldest_age_reg, oldest_age_next;
    logic [HANDLE_W-1:0]  oldest_handle_reg, oldest_handle_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0]  pend_handle_reg, pend_handle_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 status_reg, status_next;

    entry_t                  rd_q;
    entry_t                  wr_data;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic                    clr_en;
    logic [POOL_ENTRIES-1:0] valid_vec;
    cmp_t                    cmp;
    logic                    push_valid;
    result_t                 push_data;
    logic                    push_ready;

    logic                    eval_valid;
    logic                    is_last;
    logic                    take;
    logic                    match;
    logic                    report;
    logic                    stall;

    hcoe_entry_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_idx    (idx_next),
        .rd_q      (rd_q),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .clr_en    (clr_en),
        .clr_idx   (idx_reg),
        .valid_vec (valid_vec)
    );

    hcoe_cmp_unit u_cmp (
        .age_a (rd_q.age),
        .age_b (oldest_age_reg),
        .key_a (rd_q.key),
        .key_b (key_reg),
        .cmp   (cmp)
    );

    hcoe_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign eval_valid = valid_vec[idx_reg];
    assign is_last    = (idx_reg == LAST_IDX);
    assign take       = (idx_reg == '0) || cmp.age_lt;
    assign match      = eval_valid && ((cmd_reg != CMD_FREE_KEY) || cmp.key_eq);
    assign report     = match && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign stall      = report && pend_valid_reg && !push_ready;

    always_comb begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        cmd_next           = cmd_reg;
        key_next           = key_reg;
        handle_next        = handle_reg;
        age_cnt_next       = age_cnt_reg;
        shut_next          = shut_reg;
        oldest_idx_next    = oldest_idx_reg;
        oldest_age_next    = oldest_age_reg;
        oldest_handle_next = oldest_handle_reg;
        pend_valid_next    = pend_valid_reg;
        pend_handle_next   = pend_handle_reg;
        cnt_next           = cnt_reg;
        status_next        = status_reg;
        push_valid         = 1'b0;
        push_data          = '0;
        wr_en              = 1'b0;
        wr_idx             = idx_reg;
        clr_en             = 1'b0;
        wr_data.key        = key_reg;
        wr_data.handle     = handle_reg;
        wr_data.age        = age_cnt_reg + AGE_W'(1);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next         = cmd_t'(s_tuser);
                    key_next         = s_tdata[KEY_W-1:0];
                    handle_next      = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
                    idx_next         = '0;
                    pend_valid_next  = 1'b0;
                    pend_handle_next = '0;
                    cnt_next         = '0;
                    if (shut_reg) begin
                        status_next = STATUS_IGNORED;
                        state_next  = ST_FLUSH;
                    end else begin
                        status_next = STATUS_DONE;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cmd_reg == CMD_RELEASE) begin
                    if (!eval_valid) begin
                        // empty entry: fill it, nothing evicted
                        push_valid = 1'b1;
                        push_data  = '{freed_valid: 1'b0, freed_handle: '0,
                                       status: STATUS_DONE, last: 1'b1};
                        if (push_ready) begin
                            wr_en        = 1'b1;
                            wr_idx       = idx_reg;
                            age_cnt_next = age_cnt_reg + AGE_W'(1);
                            state_next   = ST_IDLE;
                        end
                    end else if (is_last) begin
                        // pool full: evict the oldest, lowest index on ties
                        push_valid = 1'b1;
                        push_data  = '{freed_valid: 1'b1,
                                       freed_handle: take ? rd_q.handle
                                                          : oldest_handle_reg,
                                       status: STATUS_DONE, last: 1'b1};
                        if (push_ready) begin
                            wr_en        = 1'b1;
                            wr_idx       = take ? idx_reg : oldest_idx_reg;
                            age_cnt_next = age_cnt_reg + AGE_W'(1);
                            state_next   = ST_IDLE;
                        end
                    end else begin
                        if (take) begin
                            oldest_idx_next    = idx_reg;
                            oldest_age_next    = rd_q.age;
                            oldest_handle_next = rd_q.handle;
                        end
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end else begin
                    // hand over the pending handle once another one shows up
                    if (report && pend_valid_reg) begin
                        push_valid = 1'b1;
                        push_data  = '{freed_valid: 1'b1, freed_handle: pend_handle_reg,
                                       status: STATUS_DONE, last: 1'b0};
                    end
                    if (!stall) begin
                        clr_en = match;
                        if (report) begin
                            pend_valid_next  = 1'b1;
                            pend_handle_next = rd_q.handle;
                            cnt_next         = cnt_reg + CNT_W'(1);
                        end
                        if (is_last) begin
                            state_next = ST_FLUSH;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
            end
            ST_FLUSH: begin
                push_valid = 1'b1;
                push_data  = '{freed_valid: pend_valid_reg, freed_handle: pend_handle_reg,
                               status: status_reg, last: 1'b1};
                if (push_ready) begin
                    if ((cmd_reg == CMD_SHUTDOWN) && (status_reg == STATUS_DONE)) begin
                        shut_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            age_cnt_reg <= '0;
            shut_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            age_cnt_reg <= age_cnt_next;
            shut_reg    <= shut_next;
        end
        idx_reg           <= idx_next;
        cmd_reg           <= cmd_next;
        key_reg           <= key_next;
        handle_reg        <= handle_next;
        oldest_idx_reg    <= oldest_idx_next;
        oldest_age_reg    <= oldest_age_next;
        oldest_handle_reg <= oldest_handle_next;
        pend_valid_reg    <= pend_valid_next;
        pend_handle_reg   <= pend_handle_next;
        cnt_reg           <= cnt_next;
        status_reg        <= status_next;
    end

endmodule

`default_nettype wire

FILE: design/hcoe_checker.sv
// ----------------------------------------------------------------------------
// hcoe_checker: port-level checks for the handle cache
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcoe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled transfer keeps its result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a result without a freed handle carries a zero handle
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("nonzero handle without freed flag");

    // an ignored command gives a single, empty result
    a_ignored_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("ignored command result malformed");

    // a command in progress holds off the next one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a command transfer");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind handle_cache_oldest_evict_core hcoe_checker u_hcoe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: verif/handle_cache_oldest_evict_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_cache_oldest_evict_core_tb: self-checking bench for the handle pool
// Drives release, free-by-key, free-all and shutdown commands through the
// stream ports under random source and sink idling. A scoreboard keeps its own
// copy of the pool, predicts every result and checks each result transfer.
// ----------------------------------------------------------------------------

module handle_cache_oldest_evict_core_tb;

    import hcoe_pkg::*;

    localparam logic [KEY_W-1:0] OWNER_A    = 32'h1357_9BDF;
    localparam logic [KEY_W-1:0] OWNER_B    = 32'h2468_ACE0;
    localparam logic [KEY_W-1:0] OWNER_NONE = 32'hDEAD_BEEF;

    class handle_pool_scoreboard;
        logic                slot_used  [POOL_ENTRIES];
        logic [KEY_W-1:0]    slot_key   [POOL_ENTRIES];
        logic [HANDLE_W-1:0] slot_handle[POOL_ENTRIES];
        logic [AGE_W-1:0]    slot_age   [POOL_ENTRIES];
        logic [AGE_W-1:0]    age_stamp;
        logic                pool_down;
        result_t             expected_q[$];
        int                  errors;

        function void clear_pool();
            for (int i = 0; i < POOL_ENTRIES; i++) begin
                slot_used[i]   = 1'b0;
                slot_key[i]    = '0;
                slot_handle[i] = '0;
                slot_age[i]    = '0;
            end
            age_stamp = '0;
            pool_down = 1'b0;
            expected_q.delete();
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic fv, logic [HANDLE_W-1:0] h, logic st, logic lst);
            result_t r;
            r.freed_valid  = fv;
            r.freed_handle = h;
            r.status       = st;
            r.last         = lst;
            expected_q = {expected_q, r};
        endfunction

        // Clear every valid entry (all of them, or only the matching owner).
        function void free_entries(logic by_key, logic [KEY_W-1:0] key);
            int n;
            n = 0;
            for (int i = 0; i < POOL_ENTRIES; i++) begin
                if (slot_used[i] && (!by_key || slot_key[i] == key)) begin
                    if (n < MAX_RESULTS) begin
                        push_result(1'b1, slot_handle[i], STATUS_DONE, 1'b0);
                        n++;
                    end
                    slot_used[i] = 1'b0;
                    slot_key[i]  = '0;
                    slot_age[i]  = '0;
                end
            end
            if (n == 0)
                push_result(1'b0, '0, STATUS_DONE, 1'b1);
            else
                expected_q[expected_q.size()-1].last = 1'b1;
        endfunction

        function void note_command(cmd_t c, logic [KEY_W-1:0] key,
                                   logic [HANDLE_W-1:0] handle);
            int                  slot;
            int                  oldest;
            logic                evict;
            logic [HANDLE_W-1:0] evicted;
            if (pool_down) begin
                push_result(1'b0, '0, STATUS_IGNORED, 1'b1);
                return;
            end
            case (c)
                CMD_RELEASE: begin
                    slot   = -1;
                    oldest = 0;
                    for (int i = 0; i < POOL_ENTRIES; i++) begin
                        if (!slot_used[i]) begin
                            slot = i;
                            break;
                        end
                        if (i == 0 || slot_age[i] < slot_age[oldest])
                            oldest = i;
                    end
                    evict   = (slot < 0);
                    evicted = evict ? slot_handle[oldest] : '0;
                    if (evict)
                        slot = oldest;
                    age_stamp         = age_stamp + 1'b1;
                    slot_used[slot]   = 1'b1;
                    slot_key[slot]    = key;
                    slot_handle[slot] = handle;
                    slot_age[slot]    = age_stamp;
                    push_result(evict, evicted, STATUS_DONE, 1'b1);
                end
                CMD_FREE_KEY: free_entries(1'b1, key);
                CMD_FREE_ALL: free_entries(1'b0, '0);
                CMD_SHUTDOWN: begin
                    pool_down = 1'b1;
                    free_entries(1'b0, '0);
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.freed_valid !== want.freed_valid) begin
                errors++;
                $display("%0t: freed_valid: expected %b, actual %b",
                         $time, want.freed_valid, got.freed_valid);
            end
            if (got.freed_handle !== want.freed_handle) begin
                errors++;
                $display("%0t: freed_handle: expected %h, actual %h",
                         $time, want.freed_handle, got.freed_handle);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status: expected %b, actual %b",
                         $time, want.status, got.status);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last: expected %b, actual %b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = CMD_RELEASE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    handle_pool_scoreboard pool_sb;
    int                    src_idle_pct = 13;
    int                    snk_idle_pct = 73;
    int                    hold_left    = 0;
    logic [KEY_W-1:0]      owner_pool[4];

    always #2 aclk = ~aclk;

    handle_cache_oldest_evict_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Sink side: random backpressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.freed_valid  = m_tuser[0];
            seen.freed_handle = m_tdata;
            seen.status       = m_tuser[1];
            seen.last         = m_tlast;
            pool_sb.check_result(seen);
        end
    end

    // Call right after a rising edge; returns right after the accepting edge.
    task automatic send_cmd(input cmd_t c, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] handle);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {handle, key};
        do @(posedge aclk); while (!s_tready);
        pool_sb.note_command(c, key, handle);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pool_sb.pending() != 0);
    endtask

    // Mostly owners from a small set so that free-by-key hits several entries.
    function automatic logic [KEY_W-1:0] pick_owner();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return owner_pool[$urandom_range(0, 3)];
        else if (r < 75)
            return '0;
        else if (r < 80)
            return '1;
        return $urandom;
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct, input int count);
        int r;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int n = 0; n < count; n++) begin
            if (n == 40)
                hold_left = 90;
            if (n == 100)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 62)
                send_cmd(CMD_RELEASE, pick_owner(), 16'($urandom));
            else if (r < 88)
                send_cmd(CMD_FREE_KEY, pick_owner(), 16'($urandom));
            else
                send_cmd(CMD_FREE_ALL, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        pool_sb = new;
        pool_sb.clear_pool();
        owner_pool[0] = OWNER_A;
        owner_pool[1] = OWNER_B;
        owner_pool[2] = $urandom;
        owner_pool[3] = $urandom;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Frees on an empty pool report no freed handle.
        send_cmd(CMD_FREE_ALL, '0, '0);
        send_cmd(CMD_FREE_KEY, OWNER_A, '0);
        // Fill every entry, then evict the two oldest.
        send_cmd(CMD_RELEASE, OWNER_A, 16'h0000);
        send_cmd(CMD_RELEASE, OWNER_B, 16'hFFFF);
        send_cmd(CMD_RELEASE, OWNER_A, 16'h0001);
        send_cmd(CMD_RELEASE, 32'h0000_0000, 16'h8000);
        send_cmd(CMD_RELEASE, 32'hFFFF_FFFF, 16'h7FFF);
        send_cmd(CMD_RELEASE, OWNER_A, 16'h00FF);
        send_cmd(CMD_RELEASE, OWNER_B, 16'hFF00);
        send_cmd(CMD_RELEASE, OWNER_A, 16'h1234);
        send_cmd(CMD_RELEASE, OWNER_B, 16'hA5A5);
        send_cmd(CMD_RELEASE, OWNER_B, 16'h5A5A);
        // Free several by owner, then an owner that holds nothing.
        send_cmd(CMD_FREE_KEY, OWNER_A, '0);
        send_cmd(CMD_FREE_KEY, OWNER_NONE, '0);
        // Refill the holes from the lowest index up, then clear the pool.
        send_cmd(CMD_RELEASE, 32'h0000_0000, 16'h0F0F);
        send_cmd(CMD_RELEASE, 32'hFFFF_FFFF, 16'hC3C3);
        send_cmd(CMD_FREE_ALL, '0, '0);

        run_phase(13, 73, 150);
        run_phase(73, 13, 150);
        run_phase(0, 0, 150);

        // Full pool into shutdown, then every command must be ignored.
        for (int i = 0; i < POOL_ENTRIES; i++)
            send_cmd(CMD_RELEASE, pick_owner(), 16'($urandom));
        send_cmd(CMD_SHUTDOWN, $urandom, 16'($urandom));
        send_cmd(CMD_RELEASE, OWNER_A, 16'h4321);
        send_cmd(CMD_FREE_KEY, OWNER_A, '0);
        send_cmd(CMD_FREE_ALL, '0, '0);
        send_cmd(CMD_SHUTDOWN, '1, '1);

        drain_results();
        repeat (20) @(posedge aclk);
        if (pool_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
